// ===== src/mbds_pkg.sv =====
// Shared constants and types for the multibyte delimiter splitter.
`timescale 1ns / 1ps

package mbds_pkg;

	localparam int MAX_DELIM   = 8;
	localparam int DELIM_W     = MAX_DELIM * 8;
	localparam int CNT_W       = $clog2(MAX_DELIM + 1);
	localparam int SEQ_N       = MAX_DELIM + 1;
	localparam int SEQ_IDX_W   = $clog2(SEQ_N);
	localparam int NB_W        = $clog2(SEQ_N + 1);
	localparam int TOT_W       = $clog2(SEQ_N + 3);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int ADDR_W      = 6;

	localparam logic [2:0] REG_DELIM_BYTES  = 3'd0;
	localparam logic [2:0] REG_DELIM_LENGTH = 3'd1;
	localparam logic [2:0] REG_ESC_ENABLE   = 3'd2;
	localparam logic [2:0] REG_ESC_CHAR     = 3'd3;
	localparam logic [2:0] REG_REMOVE_EMPTY = 3'd4;

	typedef struct packed {
		logic [63:0] delimiter_bytes;
		logic [3:0]  delimiter_length;
		logic        escape_enable;
		logic [7:0]  escape_char;
		logic        remove_empty;
	} mbds_cfg_t;

	// One queued burst: token bytes first, then end markers.
	typedef struct packed {
		logic [SEQ_N-1:0][7:0] bytes;
		logic [NB_W-1:0]       nbytes;
		logic [1:0]            nmarks;
	} mbds_entry_t;

endpackage

// ===== src/mbds_front.sv =====
// Front end: delimiter window, quoting state and burst classification.
`timescale 1ns / 1ps

module mbds_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbds_pkg::mbds_cfg_t    cfg,
	input  logic                   in_fire,
	input  logic [7:0]             in_byte,
	input  logic                   byte_present,
	input  logic                   end_of_string,
	output logic                   push,
	output mbds_pkg::mbds_entry_t  entry
);

	logic [7:0]                      win_q [mbds_pkg::MAX_DELIM];
	logic [mbds_pkg::CNT_W-1:0]      cnt_q;
	logic                            inq_q;
	logic                            thb_q;

	logic [7:0]                      seq_n [mbds_pkg::SEQ_N];
	logic [7:0]                      seq_q [mbds_pkg::SEQ_N];
	logic [7:0]                      win_mid [mbds_pkg::MAX_DELIM];
	logic [mbds_pkg::DELIM_W-1:0]    delim_ext;
	logic [mbds_pkg::CNT_W-1:0]      eff_len;
	logic [mbds_pkg::CNT_W-1:0]      ej;
	logic [mbds_pkg::CNT_W-1:0]      cnt_pre;
	logic [mbds_pkg::CNT_W-1:0]      cnt_mid;
	logic [mbds_pkg::NB_W-1:0]       n_a;
	logic                            quoted;
	logic                            esc_hit;
	logic                            match;
	logic                            thb_a;
	logic                            thb_mid;
	logic                            inq_mid;
	logic                            e1;
	logic                            e2;

	assign delim_ext = mbds_pkg::DELIM_W'(cfg.delimiter_bytes);
	assign quoted    = cfg.escape_enable && inq_q;
	assign esc_hit   = cfg.escape_enable && (in_byte == cfg.escape_char);

	always_comb begin
		if (cfg.delimiter_length == '0)
			eff_len = mbds_pkg::CNT_W'(1);
		else if (int'(cfg.delimiter_length) > mbds_pkg::MAX_DELIM)
			eff_len = mbds_pkg::CNT_W'(mbds_pkg::MAX_DELIM);
		else
			eff_len = mbds_pkg::CNT_W'(cfg.delimiter_length);
	end

	// Old window followed by the new byte, and the new byte followed by the window.
	always_comb begin
		for (int i = 0; i < mbds_pkg::SEQ_N; i++) begin
			if (i < mbds_pkg::MAX_DELIM && mbds_pkg::CNT_W'(i) < cnt_q)
				seq_n[i] = win_q[(i < mbds_pkg::MAX_DELIM) ? i : 0];
			else
				seq_n[i] = in_byte;
			seq_q[i] = (i == 0) ? in_byte : win_q[(i > 0) ? i - 1 : 0];
		end
	end

	assign ej      = (cnt_q >= eff_len) ? cnt_q - eff_len + mbds_pkg::CNT_W'(1) : '0;
	assign cnt_pre = cnt_q - ej + mbds_pkg::CNT_W'(1);

	always_comb begin
		for (int i = 0; i < mbds_pkg::MAX_DELIM; i++) begin
			if (i + int'(ej) <= mbds_pkg::MAX_DELIM)
				win_mid[i] = seq_n[mbds_pkg::SEQ_IDX_W'(i + int'(ej))];
			else
				win_mid[i] = '0;
		end
	end

	always_comb begin
		match = (cnt_pre == eff_len);
		for (int i = 0; i < mbds_pkg::MAX_DELIM; i++) begin
			if (mbds_pkg::CNT_W'(i) < eff_len && win_mid[i] != delim_ext[8*i +: 8])
				match = 1'b0;
		end
	end

	assign thb_a = thb_q || (ej != '0);

	always_comb begin
		n_a     = '0;
		e1      = 1'b0;
		cnt_mid = cnt_q;
		thb_mid = thb_q;
		inq_mid = inq_q;
		if (byte_present) begin
			priority if (quoted) begin
				n_a     = mbds_pkg::NB_W'(1);
				thb_mid = 1'b1;
				inq_mid = (in_byte != cfg.escape_char);
			end else if (esc_hit) begin
				n_a     = mbds_pkg::NB_W'(cnt_q) + mbds_pkg::NB_W'(1);
				thb_mid = 1'b1;
				inq_mid = 1'b1;
				cnt_mid = '0;
			end else if (match) begin
				n_a     = mbds_pkg::NB_W'(ej);
				e1      = !(cfg.remove_empty && !thb_a);
				thb_mid = 1'b0;
				cnt_mid = '0;
			end else begin
				n_a     = mbds_pkg::NB_W'(ej);
				thb_mid = thb_a;
				cnt_mid = cnt_pre;
			end
		end
	end

	assign e2 = !(cfg.remove_empty && !(thb_mid || cnt_mid != '0));

	always_comb begin
		for (int i = 0; i < mbds_pkg::SEQ_N; i++)
			entry.bytes[i] = (byte_present && quoted) ? seq_q[i] : seq_n[i];
		entry.nbytes = n_a + (end_of_string ? mbds_pkg::NB_W'(cnt_mid) : '0);
		entry.nmarks = {1'b0, e1} + {1'b0, end_of_string && e2};
	end

	assign push = in_fire && (entry.nbytes != '0 || entry.nmarks != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			inq_q <= 1'b0;
			thb_q <= 1'b0;
		end else if (in_fire) begin
			if (end_of_string) begin
				cnt_q <= '0;
				inq_q <= 1'b0;
				thb_q <= 1'b0;
			end else begin
				cnt_q <= cnt_mid;
				inq_q <= inq_mid;
				thb_q <= thb_mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && byte_present && !quoted) begin
			for (int i = 0; i < mbds_pkg::MAX_DELIM; i++)
				win_q[i] <= win_mid[i];
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mbds_pkg::CNT_W'(mbds_pkg::MAX_DELIM))
		else $error("window count above maximum");

endmodule

// ===== src/mbds_queue.sv =====
// Burst queue between front and back ends.
`timescale 1ns / 1ps

module mbds_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mbds_pkg::mbds_entry_t  push_entry,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output mbds_pkg::mbds_entry_t  head_entry
);

	mbds_pkg::mbds_entry_t          mem_q [mbds_pkg::QUEUE_DEPTH];
	logic [mbds_pkg::QPTR_W-1:0]    wr_q;
	logic [mbds_pkg::QPTR_W-1:0]    rd_q;
	logic [mbds_pkg::QPTR_W:0]      count_q;

	assign full       = (count_q == (mbds_pkg::QPTR_W + 1)'(mbds_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + mbds_pkg::QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + mbds_pkg::QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (mbds_pkg::QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (mbds_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

endmodule

// ===== src/mbds_back.sv =====
// Back end: serializes one queued burst into result beats.
`timescale 1ns / 1ps

module mbds_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  mbds_pkg::mbds_entry_t  head_entry,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic [mbds_pkg::TOT_W-1:0] idx_q;
	logic [mbds_pkg::TOT_W-1:0] total;
	logic                       is_byte;

	assign total    = mbds_pkg::TOT_W'(head_entry.nbytes) + mbds_pkg::TOT_W'(head_entry.nmarks);
	assign is_byte  = (idx_q < mbds_pkg::TOT_W'(head_entry.nbytes));
	assign m_tvalid = head_valid;
	assign m_tdata  = is_byte ? head_entry.bytes[idx_q[mbds_pkg::SEQ_IDX_W-1:0]] : 8'h00;
	assign m_tuser  = !is_byte;
	assign m_tlast  = (idx_q == total - mbds_pkg::TOT_W'(1));
	assign pop      = m_tvalid && m_tready && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (m_tvalid && m_tready) begin
			if (m_tlast)
				idx_q <= '0;
			else
				idx_q <= idx_q + mbds_pkg::TOT_W'(1);
		end
	end

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> idx_q < total)
		else $error("beat index past end of burst");

	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> total != '0)
		else $error("empty burst in queue");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("beat index not cleared after burst");

endmodule

// ===== src/multibyte_delimiter_splitter.sv =====
// Top level: register port, front end, burst queue and back end.
`timescale 1ns / 1ps

// Splits a byte stream into tokens at a delimiter of 1 to 8 bytes, with optional
// quoting by an escape byte. One input beat is taken per cycle while the four-entry
// burst queue has room; each beat that yields results queues one burst, and the back
// end sends one result beat per cycle while m_tready is high, so the input stalls
// once the queue fills.
// The results of an accepted beat are written to the burst queue and sent from its head.
module multibyte_delimiter_splitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbds_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // in_byte
	input  logic                        s_tuser,  // byte_present
	input  logic                        s_tlast,  // end_of_string
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // out_byte
	output logic                        m_tuser,  // kind
	output logic                        m_tlast   // last_of_run
);

	mbds_pkg::mbds_cfg_t   cfg_q;
	mbds_pkg::mbds_entry_t push_entry;
	mbds_pkg::mbds_entry_t head_entry;
	logic [2:0]            reg_idx;
	logic                  wr_en;
	logic                  in_fire;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  head_valid;

	assign pready  = 1'b1;
	assign reg_idx = paddr[mbds_pkg::ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_bytes  <= 64'd44;
			cfg_q.delimiter_length <= 4'd1;
			cfg_q.escape_enable    <= 1'b0;
			cfg_q.escape_char      <= 8'd34;
			cfg_q.remove_empty     <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				mbds_pkg::REG_DELIM_BYTES:  cfg_q.delimiter_bytes  <= pwdata;
				mbds_pkg::REG_DELIM_LENGTH: cfg_q.delimiter_length <= pwdata[3:0];
				mbds_pkg::REG_ESC_ENABLE:   cfg_q.escape_enable    <= pwdata[0];
				mbds_pkg::REG_ESC_CHAR:     cfg_q.escape_char      <= pwdata[7:0];
				mbds_pkg::REG_REMOVE_EMPTY: cfg_q.remove_empty     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mbds_pkg::REG_DELIM_BYTES:  prdata = cfg_q.delimiter_bytes;
			mbds_pkg::REG_DELIM_LENGTH: prdata = {60'd0, cfg_q.delimiter_length};
			mbds_pkg::REG_ESC_ENABLE:   prdata = {63'd0, cfg_q.escape_enable};
			mbds_pkg::REG_ESC_CHAR:     prdata = {56'd0, cfg_q.escape_char};
			mbds_pkg::REG_REMOVE_EMPTY: prdata = {63'd0, cfg_q.remove_empty};
			default:                    prdata = 64'd0;
		endcase
	end

	assign s_tready = !full;
	assign in_fire  = s_tvalid && s_tready;

	mbds_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_fire       (in_fire),
		.in_byte       (s_tdata),
		.byte_present  (s_tuser),
		.end_of_string (s_tlast),
		.push          (push),
		.entry         (push_entry)
	);

	mbds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	mbds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
